// ----- src/nad_pkg.sv -----
// Shared types and constants of the neuron activation unit with derivative.
// Used by the channel interfaces and by the core; depends on nothing else.
package nad_pkg;

  // Payload widths of the streaming channels.
  localparam int DATA_W = 16;
  localparam int DER_W  = 13;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_ACT_KIND = 1'b0;

  // Largest derivative that fits the output field.
  localparam logic [DER_W-1:0] DER_MAX = {DER_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_LOGISTIC = 2'd0,
    KIND_BIPOLAR  = 2'd1,
    KIND_LINEAR   = 2'd2,
    KIND_RELU     = 2'd3
  } act_kind_e;

endpackage

// ----- src/nad_if.sv -----
// Valid/ready channel interfaces for the activation unit's input and result beats.
// Depends on nad_pkg for the payload widths.
interface nad_in_if;
  import nad_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pre_activation;
  logic signed [DATA_W-1:0] bias;

  modport source (output valid, pre_activation, bias, input ready);
  modport sink   (input valid, pre_activation, bias, output ready);
endinterface

interface nad_out_if;
  import nad_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] activation;
  logic        [DER_W-1:0]  derivative;

  modport source (output valid, activation, derivative, input ready);
  modport sink   (input valid, activation, derivative, output ready);
endinterface

// ----- src/neuron_activation_with_derivative_core.sv -----
// Neuron activation unit with derivative: a seven-stage pipeline that accepts one beat per
// cycle. While the result side stalls, occupied stages hold and empty stages behind them
// keep filling, so input stalls only once all seven stages are full. The saturated sum of
// pre_activation and bias feeds the kind chosen in activation_kind: the sigmoid kinds read
// two neighbor entries of a constant table through a registered two-port ROM, interpolate,
// and form s(1-s) in the derivative stage.
// Depends on nad_pkg and the channel interfaces in nad_if.sv.
module neuron_activation_with_derivative_core #(
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nad_in_if.sink                      in_i,
  nad_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nad_pkg::APB_AW-1:0]  paddr,
  input  logic [nad_pkg::APB_DW-1:0]  pwdata,
  output logic [nad_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import nad_pkg::*;

  localparam int NST = 7;
  localparam int K   = FRAC_BITS + 3;          // fraction bits of the table position
  localparam int TW  = FRAC_BITS + 1;          // table entry and sigmoid width
  localparam int IW  = $clog2(TABLE_ENTRIES + 1);
  localparam int PW  = DATA_W + 1 + IW;        // |sum| times the entry count
  localparam int XW  = PW - K;
  localparam int QW  = 2 * TW + 1;             // doubled s(1-s)
  localparam int DW  = QW - FRAC_BITS;
  localparam logic [63:0] H = (64'd1 << 34) / TABLE_ENTRIES;
  localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [DATA_W:0] ONE_S = {{(DATA_W - FRAC_BITS){1'b0}}, ONE};
  localparam logic [DER_W-1:0] DER_ONE =
    ((DER_W + TW)'(ONE) > (DER_W + TW)'(DER_MAX)) ? DER_MAX : DER_W'(ONE);

  typedef logic [TW-1:0] tab_t [TABLE_ENTRIES + 1];

  // Shift-subtract division for building the table at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry i is the sigmoid at 8*i/TABLE_ENTRIES; e^-x is stepped by a Taylor-built ratio.
  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] r;
    logic [63:0] p;
    logic [63:0] d;
    term  = 64'd1 << 31;
    plus  = term;
    minus = '0;
    for (int k = 1; k <= 16; k++) begin
      term = udiv64((term * H) >> 31, 64'(k));
      if (k % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    r = plus - minus;
    p = 64'd1 << 31;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      d    = (64'd1 << 31) + p;
      t[i] = TW'(udiv64((64'd1 << (31 + FRAC_BITS)) + (d >> 1), d));
      p    = (p * r + (64'd1 << 30)) >> 31;
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  // ---------------------------------------------------------------- configuration
  act_kind_e kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_LOGISTIC;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACT_KIND)) begin
      kind_q <= act_kind_e'(pwdata[1:0]);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACT_KIND) ? APB_DW'(kind_q) : '0;

  // ---------------------------------------------------------------- stage control
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_o.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: saturated sum
  logic signed [DATA_W:0]   wide_sum;
  logic signed [DATA_W-1:0] sum_d;
  logic signed [DATA_W-1:0] s1_sum_q;

  always_comb begin
    wide_sum = {in_i.pre_activation[DATA_W-1], in_i.pre_activation}
             + {in_i.bias[DATA_W-1], in_i.bias};
    if (wide_sum[DATA_W] != wide_sum[DATA_W-1]) begin
      sum_d = wide_sum[DATA_W] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
    end else begin
      sum_d = wide_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sum_q <= sum_d;
    end
  end

  // ---------------------------------------------------------------- stage 2: table position
  logic [DATA_W:0]          mag;
  logic [PW-1:0]            s2_pos_q;
  logic                     s2_neg_q;
  logic signed [DATA_W-1:0] s2_sum_q;

  assign mag = s1_sum_q[DATA_W-1] ? (DATA_W + 1)'(-(DATA_W + 1)'(s1_sum_q))
                                  : (DATA_W + 1)'(s1_sum_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_pos_q <= PW'(mag) * PW'(TABLE_ENTRIES);
      s2_neg_q <= s1_sum_q[DATA_W-1];
      s2_sum_q <= s1_sum_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: ROM read
  logic [XW-1:0]            idx_full;
  logic                     past_end;
  logic [IW-1:0]            idx;
  logic [K:0]               frac_d;
  logic [TW-1:0]            s3_a_q;
  logic [TW-1:0]            s3_b_q;
  logic [K:0]               s3_frac_q;
  logic                     s3_neg_q;
  logic signed [DATA_W-1:0] s3_sum_q;

  // Past the table end, interpolating the last pair with a full-step weight gives the
  // last entry exactly.
  always_comb begin
    idx_full = s2_pos_q[PW-1:K];
    past_end = idx_full >= XW'(TABLE_ENTRIES);
    if (past_end) begin
      idx    = IW'(TABLE_ENTRIES - 1);
      frac_d = {1'b1, {K{1'b0}}};
    end else begin
      idx    = idx_full[IW-1:0];
      frac_d = {1'b0, s2_pos_q[K-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_a_q    <= SIG_TAB[idx];
      s3_b_q    <= SIG_TAB[idx + IW'(1)];
      s3_frac_q <= frac_d;
      s3_neg_q  <= s2_neg_q;
      s3_sum_q  <= s2_sum_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: slope product
  logic                     falling;
  logic [TW-1:0]            slope;
  logic [TW+K:0]            s4_prod_q;
  logic [TW-1:0]            s4_a_q;
  logic                     s4_down_q;
  logic                     s4_neg_q;
  logic signed [DATA_W-1:0] s4_sum_q;

  assign falling = s3_b_q < s3_a_q;
  assign slope   = falling ? s3_a_q - s3_b_q : s3_b_q - s3_a_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_prod_q <= (TW + K + 1)'(slope) * (TW + K + 1)'(s3_frac_q);
      s4_a_q    <= s3_a_q;
      s4_down_q <= falling;
      s4_neg_q  <= s3_neg_q;
      s4_sum_q  <= s3_sum_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: sigmoid value
  logic [TW-1:0]            step;
  logic [TW-1:0]            v;
  logic [TW-1:0]            s5_s_q;
  logic signed [DATA_W-1:0] s5_sum_q;

  assign step = s4_prod_q[K +: TW];
  assign v    = s4_down_q ? s4_a_q - step : s4_a_q + step;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_s_q   <= s4_neg_q ? ONE - v : v;
      s5_sum_q <= s4_sum_q;
    end
  end

  // ---------------------------------------------------------------- stage 6: s(1-s)
  logic [2*TW-1:0]          s6_prod_q;
  logic [TW-1:0]            s6_s_q;
  logic signed [DATA_W-1:0] s6_sum_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_prod_q <= (2 * TW)'(s5_s_q) * (2 * TW)'(ONE - s5_s_q);
      s6_s_q    <= s5_s_q;
      s6_sum_q  <= s5_sum_q;
    end
  end

  // ---------------------------------------------------------------- stage 7: result
  logic [QW-1:0]            prod_x;
  logic [QW-1:0]            prod_rnd;
  logic [DW-1:0]            der_full;
  logic [DW+DER_W-1:0]      der_wide;
  logic [DER_W-1:0]         der_sig;
  logic signed [DATA_W:0]   sum_x;
  logic signed [DATA_W:0]   bip;
  logic signed [DATA_W-1:0] act_d;
  logic [DER_W-1:0]         der_d;
  logic signed [DATA_W-1:0] act_q;
  logic [DER_W-1:0]         der_q;

  always_comb begin
    prod_x   = (kind_q == KIND_BIPOLAR) ? {s6_prod_q, 1'b0} : {1'b0, s6_prod_q};
    prod_rnd = prod_x + QW'(ONE >> 1);
    der_full = prod_rnd[QW-1:FRAC_BITS];
    der_wide = (DW + DER_W)'(der_full);
    der_sig  = (der_wide > (DW + DER_W)'(DER_MAX)) ? DER_MAX : der_wide[DER_W-1:0];
    sum_x    = {s6_sum_q[DATA_W-1], s6_sum_q};
    bip      = (DATA_W + 1)'({s6_s_q, 1'b0}) - ONE_S;
    case (kind_q)
      KIND_LOGISTIC: begin
        act_d = DATA_W'(s6_s_q);
        der_d = der_sig;
      end
      KIND_BIPOLAR: begin
        act_d = bip[DATA_W-1:0];
        der_d = der_sig;
      end
      KIND_LINEAR: begin
        if (sum_x < -ONE_S) begin
          act_d = DATA_W'(-ONE_S);
          der_d = '0;
        end else if (sum_x > ONE_S) begin
          act_d = DATA_W'(ONE_S);
          der_d = '0;
        end else begin
          act_d = s6_sum_q;
          der_d = DER_ONE;
        end
      end
      KIND_RELU: begin
        if (s6_sum_q[DATA_W-1]) begin
          act_d = '0;
          der_d = '0;
        end else begin
          act_d = s6_sum_q;
          der_d = DER_ONE;
        end
      end
      default: begin
        act_d = '0;
        der_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      act_q <= act_d;
      der_q <= der_d;
    end
  end

  assign out_o.valid      = vld_q[NST-1];
  assign out_o.activation = act_q;
  assign out_o.derivative = der_q;

endmodule

// ----- tb/sv/neuron_activation_with_derivative_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the neuron activation unit with derivative.
// It drives the input and result channels and the APB port. Every result is compared
// with a fixed-point predictor. Depends on nad_pkg, nad_if.sv and the core.
module neuron_activation_with_derivative_core_tb;
  import nad_pkg::*;

  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 256;
  localparam int ONE           = 1 << FRAC_BITS;
  localparam int PIPE_LATENCY  = 7;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_WAIT      = 11;
  localparam logic [APB_AW-1:0] KIND_ADDR = {REG_ACT_KIND, 2'b00};

  typedef struct {
    logic signed [DATA_W-1:0] activation;
    logic        [DER_W-1:0]  derivative;
  } act_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nad_in_if  in_bus ();
  nad_out_if out_bus ();

  neuron_activation_with_derivative_core #(
    .FRAC_BITS    (FRAC_BITS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  longint unsigned sigmoid_lut [0:TABLE_ENTRIES];
  act_result_t     expected_results [$];
  act_result_t     oldest_result;
  act_kind_e       current_kind;
  bit              idle_on;
  int              stall_left;
  int              hold_off_left;
  int              fail_count;
  int              results_checked;
  int              cycle_count;
  int              kind_beats [4];

  // Sigmoid samples at 8*i/TABLE_ENTRIES, built with the same Q31 exponential recurrence
  // as the hardware constant table so that the rounding matches bit for bit.
  function automatic void build_sigmoid_lut();
    longint unsigned step, term, plus, minus, ratio, p, d;
    step  = (64'd8 << 31) / TABLE_ENTRIES;
    term  = 64'd1 << 31;
    plus  = term;
    minus = 0;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * step) >> 31) / k;
      if (k % 2 == 1) minus += term;
      else plus += term;
    end
    ratio = plus - minus;
    p     = 64'd1 << 31;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      d              = (64'd1 << 31) + p;
      sigmoid_lut[i] = ((64'd1 << (31 + FRAC_BITS)) + d / 2) / d;
      p              = (p * ratio + (64'd1 << 30)) >> 31;
    end
  endfunction

  function automatic int sigmoid_q(int x);
    longint unsigned mag, pos, idx, frac, a, b, v;
    mag  = (x < 0) ? longint'(-x) : longint'(x);
    pos  = mag * TABLE_ENTRIES;
    idx  = pos >> (FRAC_BITS + 3);
    frac = pos & ((64'd1 << (FRAC_BITS + 3)) - 1);
    if (idx >= TABLE_ENTRIES) begin
      v = sigmoid_lut[TABLE_ENTRIES];
    end else begin
      a = sigmoid_lut[idx];
      b = sigmoid_lut[idx + 1];
      if (b >= a) v = a + (((b - a) * frac) >> (FRAC_BITS + 3));
      else v = a - (((a - b) * frac) >> (FRAC_BITS + 3));
    end
    return (x < 0) ? ONE - int'(v) : int'(v);
  endfunction

  function automatic act_result_t predict_activation(act_kind_e kind,
                                                     logic signed [DATA_W-1:0] pre,
                                                     logic signed [DATA_W-1:0] bias);
    int          sum, s, act;
    longint      prod, der;
    act_result_t r;
    sum = int'(pre) + int'(bias);
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    case (kind)
      KIND_LOGISTIC, KIND_BIPOLAR: begin
        s    = sigmoid_q(sum);
        prod = longint'(s) * (ONE - s);
        if (kind == KIND_BIPOLAR) begin
          act  = 2 * s - ONE;
          prod = prod * 2;
        end else begin
          act = s;
        end
        der = (prod + ONE / 2) >>> FRAC_BITS;
      end
      KIND_LINEAR: begin
        if (sum < -ONE) begin
          act = -ONE;
          der = 0;
        end else if (sum > ONE) begin
          act = ONE;
          der = 0;
        end else begin
          act = sum;
          der = ONE;
        end
      end
      default: begin
        if (sum < 0) begin
          act = 0;
          der = 0;
        end else begin
          act = sum;
          der = ONE;
        end
      end
    endcase
    if (der > longint'(DER_MAX)) der = longint'(DER_MAX);
    if (der < 0) der = 0;
    r.activation = act[DATA_W-1:0];
    r.derivative = der[DER_W-1:0];
    return r;
  endfunction

  // Result side: a random stall per beat, plus a long hold-off when a test asks for one.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation: activation %0d derivative %0d",
               out_bus.activation, out_bus.derivative);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_bus.activation !== oldest_result.activation) begin
          $error("activation: expected %0d, actual %0d",
                 oldest_result.activation, out_bus.activation);
          fail_count++;
        end
        if (out_bus.derivative !== oldest_result.derivative) begin
          $error("derivative: expected %0d, actual %0d",
                 oldest_result.derivative, out_bus.derivative);
          fail_count++;
        end
      end
      stall_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The previous beat stays on the bus until the next falling edge, where it is either
  // replaced or withdrawn for the drawn gap.
  task automatic send_beat(logic signed [DATA_W-1:0] pre, logic signed [DATA_W-1:0] bias);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.pre_activation <= pre;
    in_bus.bias           <= bias;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_results.push_back(predict_activation(current_kind, pre, bias));
    kind_beats[current_kind]++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_kind_readback(act_kind_e want_kind);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= KIND_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[1:0] !== want_kind) begin
      $error("activation_kind readback: expected %0d, actual %0d", want_kind, prdata[1:0]);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The pipeline must be empty before the kind changes under it.
  task automatic set_kind(act_kind_e kind);
    wait_results_drained();
    repeat (PIPE_LATENCY + 3) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KIND_ADDR;
    pwdata  <= APB_DW'(kind);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    current_kind = kind;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_kind_readback(kind);
  endtask

  task automatic random_operands(output logic signed [DATA_W-1:0] pre,
                                 output logic signed [DATA_W-1:0] bias);
    int a, b;
    case ($urandom_range(0, 3))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        // Where the sigmoid bends and the interpolation matters most.
        a = $urandom_range(0, 49152);
        a = a - 24576;
        b = $urandom_range(0, 8192);
        b = b - 4096;
      end
      2: begin
        // Around the clipping and rectifier corners at -1, 0 and +1.
        a = $urandom_range(0, 2);
        a = (a - 1) * ONE;
        b = $urandom_range(0, 8);
        b = b - 4;
      end
      default: begin
        // Sums that saturate, or sit at the far end of the table.
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 16383);
        if ($urandom_range(0, 1) == 1) begin
          a = 32767 - a;
        end else begin
          a = a - 32768;
          b = -b;
        end
      end
    endcase
    pre  = a[DATA_W-1:0];
    bias = b[DATA_W-1:0];
  endtask

  task automatic send_random_beats(int count);
    logic signed [DATA_W-1:0] pre, bias;
    repeat (count) begin
      random_operands(pre, bias);
      send_beat(pre, bias);
    end
  endtask

  task automatic test_register_access();
    check_kind_readback(KIND_LOGISTIC);
    set_kind(KIND_RELU);
    set_kind(KIND_LINEAR);
    set_kind(KIND_BIPOLAR);
    set_kind(KIND_LOGISTIC);
  endtask

  task automatic test_directed_points();
    act_kind_e dir_kinds [4] = '{KIND_LOGISTIC, KIND_BIPOLAR, KIND_LINEAR, KIND_RELU};
    int dir_pre [4][6] = '{
      '{32767, -32768, 0, 4096, -4096, 16383},
      '{32767, -32768, 0, 2048, -100, -1},
      '{4096, 4097, -4096, -4097, -32768, 32767},
      '{-1, 0, 1, 32767, -32768, -32768}
    };
    int dir_bias [4][6] = '{
      '{32767, -32768, 0, -1, 0, 16384},
      '{1, 0, 0, 2048, 0, 0},
      '{0, 0, 0, 0, 32767, 32767},
      '{0, 0, 0, 0, -1, 32767}
    };
    idle_on = 1'b1;
    foreach (dir_kinds[k]) begin
      set_kind(dir_kinds[k]);
      for (int j = 0; j < 6; j++) begin
        send_beat(dir_pre[k][j][DATA_W-1:0], dir_bias[k][j][DATA_W-1:0]);
      end
    end
  endtask

  task automatic test_random_kinds();
    act_kind_e order [8] = '{KIND_LOGISTIC, KIND_BIPOLAR, KIND_LINEAR, KIND_RELU,
                             KIND_RELU, KIND_LOGISTIC, KIND_BIPOLAR, KIND_LINEAR};
    foreach (order[r]) begin
      set_kind(order[r]);
      // Every third round runs back to back on both sides.
      idle_on = (r % 3 != 2);
      send_random_beats(200);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_kind(KIND_BIPOLAR);
    idle_on = 1'b0;
    @(posedge clk_i);
    hold_off_left = 150;
    send_random_beats(80);
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    set_kind(KIND_LINEAR);
    send_random_beats(35);
    wait_results_drained();
    send_random_beats(35);
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_bus.valid          = 1'b0;
    in_bus.pre_activation = '0;
    in_bus.bias           = '0;
    out_bus.ready         = 1'b0;
    current_kind          = KIND_LOGISTIC;
    idle_on               = 1'b1;
    stall_left            = 0;
    hold_off_left         = 0;
    fail_count            = 0;
    results_checked       = 0;
    cycle_count           = 0;
    build_sigmoid_lut();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_directed_points();
    test_random_kinds();
    test_output_backpressure();
    test_drain_pause();

    wait_results_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    $display("Sent %0d logistic, %0d bipolar, %0d clipped linear and %0d ReLU beats;",
             kind_beats[KIND_LOGISTIC], kind_beats[KIND_BIPOLAR],
             kind_beats[KIND_LINEAR], kind_beats[KIND_RELU]);
    $display("%0d results compared, with random stalls, a long hold-off and a drain pause.",
             results_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
